// ===== rtl/core/ppec_pkg.sv =====
// ----------------------------------------------------------------------------
// ppec_pkg
// Shared widths, register indexes, reset values and time constants for the
// predictive PPS edge capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppec_pkg;

   // timestamps: the timer value is 63 bits; TIME_BITS is 64, so NOW_MASK keeps every bit
   localparam int TIME_BITS = 64;
   localparam int NOW_W     = 63;
   localparam logic [NOW_W-1:0] NOW_MASK =
      (TIME_BITS >= NOW_W) ? {NOW_W{1'b1}} : ((NOW_W'(1) << TIME_BITS) - NOW_W'(1));

   localparam int DELAY_W = 40;
   localparam int US_W    = 20;
   // a positive microsecond count below 2^20 times 1000 stays below 2^30
   localparam int NS_W    = 30;
   localparam int READS_W = 16;
   localparam int NS_PER_US = 1000;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAPTURE_LEVEL  = 3'd0,
      REG_POLL_PERIOD    = 3'd1,
      REG_GUARD_TIME     = 3'd2,
      REG_READ_LIMIT     = 3'd3,
      REG_PULSE_INTERVAL = 3'd4
   } reg_index_type;

   localparam logic              RST_CAPTURE_LEVEL  = 1'b1;
   localparam logic [US_W-1:0]   RST_POLL_PERIOD    = 20'd100;
   localparam logic [US_W-1:0]   RST_GUARD_TIME     = 20'd15;
   localparam logic [READS_W-1:0] RST_READ_LIMIT    = 16'd2000;
   localparam logic [US_W-1:0]   RST_PULSE_INTERVAL = 20'd1000000;

   // stream payload widths
   localparam int REQ_DATA_W = 1 + READS_W + NOW_W;             // 80
   localparam int RSP_BITS   = DELAY_W + 1 + NOW_W + 1 + 1;     // 106
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;        // 112

endpackage

`default_nettype wire

// ===== rtl/core/pps_predictive_edge_capture.sv =====
// ----------------------------------------------------------------------------
// pps_predictive_edge_capture
// Predictive capture of a PPS line: each timer expiry either
// polls the line or judges a busy-wait window, and returns the next delay.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: line_level, reads_before_match, now_ns
//   rsp      out  rsp_tvalid/tready     tdata: delay, pulse flags, time; tuser: edge
//   csr      in   csr_valid/csr_ready   csr_index, csr_wdata
//
// One transaction per cycle while rsp is not stalled; a request passes the input
// register, then the result register, before rsp_tvalid rises.
// Derived nanosecond delays are registered from the configuration registers and follow a write.
// csr_ready is always high. Reset is synchronous, restores the configuration
// registers and returns the block to polling mode with no pulse seen.
// A stalled rsp channel holds its result; req stalls only when both stages
// are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_predictive_edge_capture
   import ppec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [0] line_level, [16:1] reads_before_match, [79:17] now_ns
   input  wire logic [REQ_DATA_W-1:0] req_tdata,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [39:0] next_delay_ns, [40] pulse_valid, [103:41] pulse_time_ns,
   // [104] pulse_missed, [105] waiting_mode, [111:106] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [0] pulse_edge
   output logic                       rsp_tuser,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [DELAY_W-1:0] DelayMax = {DELAY_W{1'b1}};

   // clamp a signed microsecond count to nanoseconds, zero when not positive
   function automatic logic [NS_W-1:0] us_to_ns(input logic signed [US_W+1:0] us);
      logic [NS_W-1:0] res;
      res = '0;
      if (us > 0) begin
         res = NS_W'(us[US_W-1:0]) * NS_W'(NS_PER_US);
      end
      return res;
   endfunction

   // configuration registers
   logic                capture_level_ff;
   logic [US_W-1:0]     poll_period_ff;
   logic [US_W-1:0]     guard_time_ff;
   logic [READS_W-1:0]  read_limit_ff;
   logic [US_W-1:0]     pulse_interval_ff;

   // delays derived from the registers
   logic [NS_W-1:0]     poll_ns_ff, poll_ns_in;
   logic [NS_W-1:0]     arm_ns_ff, arm_ns_in;
   logic [NS_W-1:0]     first_ns_ff, first_ns_in;
   logic [NS_W-1:0]     guard_ns_ff, guard_ns_in;

   // input stage
   logic                s1_valid_ff;
   logic                s1_level_ff;
   logic [READS_W-1:0]  s1_reads_ff;
   logic [NOW_W-1:0]    s1_now_ff;

   // block state
   logic                mode_ff, mode_in;
   logic                prev_level_ff, prev_level_in;
   logic [NOW_W-1:0]    last_ff, last_in;

   // result register
   logic                rsp_valid_ff;
   logic [DELAY_W-1:0]  rsp_delay_ff, rsp_delay_in;
   logic                rsp_pulse_ff, rsp_pulse_in;
   logic [NOW_W-1:0]    rsp_time_ff, rsp_time_in;
   logic                rsp_edge_ff;
   logic                rsp_missed_ff, rsp_missed_in;
   logic                rsp_mode_ff;

   logic                advance;
   logic                req_fire;
   logic                csr_fire;
   logic                capture;
   logic [NOW_W:0]      diff_w;
   logic [NOW_W:0]      excess_w;
   logic [DELAY_W-1:0]  period_delay;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      logic signed [US_W+1:0] poll_s;
      logic signed [US_W+1:0] ival_s;
      logic signed [US_W+1:0] half_s;
      poll_s      = $signed({2'b00, poll_period_ff});
      ival_s      = $signed({2'b00, pulse_interval_ff});
      half_s      = $signed({3'b000, poll_period_ff[US_W-1:1]});
      poll_ns_in  = NS_W'(poll_period_ff) * NS_W'(NS_PER_US);
      guard_ns_in = NS_W'(guard_time_ff) * NS_W'(NS_PER_US);
      arm_ns_in   = us_to_ns(ival_s - poll_s - half_s);
      first_ns_in = us_to_ns(ival_s - half_s);
   end

   // measured period minus guard, saturated at both ends
   always_comb begin
      diff_w   = {1'b0, s1_now_ff} - {1'b0, last_ff};
      excess_w = {1'b0, diff_w[NOW_W-1:0]} - (NOW_W+1)'(guard_ns_ff);
      if (diff_w[NOW_W] || excess_w[NOW_W]) begin
         period_delay = '0;
      end else if (|excess_w[NOW_W-1:DELAY_W]) begin
         period_delay = DelayMax;
      end else begin
         period_delay = excess_w[DELAY_W-1:0];
      end
   end

   assign capture = (s1_reads_ff != '0) && (s1_reads_ff < read_limit_ff);

   always_comb begin
      mode_in       = mode_ff;
      prev_level_in = prev_level_ff;
      last_in       = last_ff;
      rsp_delay_in  = DELAY_W'(poll_ns_ff);
      rsp_pulse_in  = 1'b0;
      rsp_time_in   = '0;
      rsp_missed_in = 1'b0;
      if (!mode_ff) begin
         if (s1_level_ff != prev_level_ff) begin
            if (s1_level_ff == capture_level_ff) begin
               rsp_delay_in = DELAY_W'(arm_ns_ff);
               mode_in      = 1'b1;
               last_in      = '0;
            end
            prev_level_in = s1_level_ff;
         end
      end else if (capture) begin
         rsp_pulse_in = 1'b1;
         rsp_time_in  = s1_now_ff;
         last_in      = s1_now_ff;
         if (last_ff == '0) begin
            rsp_delay_in = DELAY_W'(first_ns_ff);
         end else begin
            rsp_delay_in = period_delay;
         end
      end else begin
         rsp_missed_in = 1'b1;
         mode_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      poll_ns_ff  <= poll_ns_in;
      arm_ns_ff   <= arm_ns_in;
      first_ns_ff <= first_ns_in;
      guard_ns_ff <= guard_ns_in;

      if (req_fire) begin
         s1_level_ff <= req_tdata[0];
         s1_reads_ff <= req_tdata[READS_W:1];
         s1_now_ff   <= req_tdata[REQ_DATA_W-1:READS_W+1] & NOW_MASK;
      end

      if (s1_valid_ff && advance) begin
         rsp_delay_ff  <= rsp_delay_in;
         rsp_pulse_ff  <= rsp_pulse_in;
         rsp_time_ff   <= rsp_time_in;
         rsp_edge_ff   <= capture_level_ff;
         rsp_missed_ff <= rsp_missed_in;
         rsp_mode_ff   <= mode_in;
      end

      if (reset) begin
         capture_level_ff  <= RST_CAPTURE_LEVEL;
         poll_period_ff    <= RST_POLL_PERIOD;
         guard_time_ff     <= RST_GUARD_TIME;
         read_limit_ff     <= RST_READ_LIMIT;
         pulse_interval_ff <= RST_PULSE_INTERVAL;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         mode_ff           <= 1'b0;
         prev_level_ff     <= 1'b0;
         last_ff           <= '0;
      end else begin
         if (csr_fire) begin
            case (csr_index)
               REG_CAPTURE_LEVEL:  capture_level_ff  <= csr_wdata[0];
               REG_POLL_PERIOD:    poll_period_ff    <= csr_wdata[US_W-1:0];
               REG_GUARD_TIME:     guard_time_ff     <= csr_wdata[US_W-1:0];
               REG_READ_LIMIT:     read_limit_ff     <= csr_wdata[READS_W-1:0];
               REG_PULSE_INTERVAL: pulse_interval_ff <= csr_wdata[US_W-1:0];
               default: ;
            endcase
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_valid_ff && advance) begin
            mode_ff       <= mode_in;
            prev_level_ff <= prev_level_in;
            last_ff       <= last_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_mode_ff, rsp_missed_ff,
                        rsp_time_ff, rsp_pulse_ff, rsp_delay_ff};
   assign rsp_tuser  = rsp_edge_ff;

`ifndef SYNTHESIS
   // a result is either a capture, a miss or a polling step, never two of them
   a_capture_or_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_pulse_ff && rsp_missed_ff))
      else $error("capture and miss flagged together");

   // a miss always drops back to polling, a capture always stays waiting
   a_mode_after: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_missed_ff || !rsp_mode_ff) && (!rsp_pulse_ff || rsp_mode_ff))
      else $error("mode after result inconsistent with its flags");

   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_pulse_ff) |-> (rsp_time_ff == '0))
      else $error("timestamp set without a capture");

   a_limit_write: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && csr_index == REG_READ_LIMIT) |=>
         (read_limit_ff == $past(csr_wdata[READS_W-1:0])))
      else $error("read limit write lost");

   // leaving polling mode always clears the stored pulse time
   a_arm_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(mode_ff) |-> (last_ff == '0))
      else $error("stored pulse time not cleared on arming");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_pps_predictive_edge_capture.sv =====
// ----------------------------------------------------------------------------
// tb_pps_predictive_edge_capture
// Self-checking bench for the predictive PPS edge capture block.
// A scoreboard class predicts every result from the timer expiries accepted on
// the req stream and checks the rsp stream field by field. Directed expiries
// cover the corner cases at reset settings. Randomized expiries then run under
// several register settings, extremes included, with random gaps on both
// streams, one long rsp stall and one burst with no gaps.
// ----------------------------------------------------------------------------

module tb_pps_predictive_edge_capture;
   timeunit 1ns;
   timeprecision 1ps;

   import ppec_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 3;
   localparam int LATENCY_CYCLES = 4;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int IDLE_PERCENT   = 34;
   localparam int ITEMS_PER_SETTING = 60;
   localparam int SETTING_COUNT  = 8;
   localparam longint unsigned DELAY_LIMIT = (64'd1 << DELAY_W) - 64'd1;
   // no register lives here, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [DELAY_W-1:0] next_delay;
      logic               pulse_valid;
      logic [NOW_W-1:0]   pulse_time;
      logic               pulse_edge;
      logic               pulse_missed;
      logic               waiting_mode;
   } expiry_result_type;

   // -------------------------------------------------------------------------
   class pulse_capture_scoreboard_type;
      logic                cfg_level;
      logic [US_W-1:0]     cfg_poll;
      logic [US_W-1:0]     cfg_guard;
      logic [READS_W-1:0]  cfg_limit;
      logic [US_W-1:0]     cfg_interval;
      logic                waiting;
      logic                prev_level;
      logic [63:0]         last_pulse;
      expiry_result_type   expected_q[$];
      int errors;
      int expiries;
      int captures;
      int misses;
      int arms;
      int writes;

      function new();
         cfg_level    = RST_CAPTURE_LEVEL;
         cfg_poll     = RST_POLL_PERIOD;
         cfg_guard    = RST_GUARD_TIME;
         cfg_limit    = RST_READ_LIMIT;
         cfg_interval = RST_PULSE_INTERVAL;
         waiting      = 1'b0;
         prev_level   = 1'b0;
         last_pulse   = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         writes++;
         case (idx)
            REG_CAPTURE_LEVEL:  cfg_level    = value[0];
            REG_POLL_PERIOD:    cfg_poll     = value[US_W-1:0];
            REG_GUARD_TIME:     cfg_guard    = value[US_W-1:0];
            REG_READ_LIMIT:     cfg_limit    = value[READS_W-1:0];
            REG_PULSE_INTERVAL: cfg_interval = value[US_W-1:0];
            default: ;
         endcase
      endfunction

      // microseconds to a nanosecond delay, clamped at zero and at the field max
      function logic [DELAY_W-1:0] us_to_delay(longint us);
         longint unsigned ns;
         if (us <= 0) return '0;
         ns = us;
         ns = ns * NS_PER_US;
         return (ns > DELAY_LIMIT) ? DELAY_LIMIT[DELAY_W-1:0] : ns[DELAY_W-1:0];
      endfunction

      function void note_request(logic [REQ_DATA_W-1:0] data);
         logic                level;
         logic [READS_W-1:0]  reads;
         logic [63:0]         now;
         longint              poll;
         longint              interval;
         longint unsigned     guard_ns;
         longint unsigned     span;
         expiry_result_type   predicted;
         level    = data[0];
         reads    = data[READS_W:1];
         now      = {1'b0, data[REQ_DATA_W-1:READS_W+1] & NOW_MASK};
         poll     = longint'(cfg_poll);
         interval = longint'(cfg_interval);
         predicted = '0;
         predicted.pulse_edge = cfg_level;
         expiries++;
         if (!waiting) begin
            predicted.next_delay = us_to_delay(poll);
            if (level != prev_level) begin
               if (level == cfg_level) begin
                  predicted.next_delay = us_to_delay(interval - poll - poll / 2);
                  waiting    = 1'b1;
                  last_pulse = '0;
                  arms++;
               end
               prev_level = level;
            end
         end else if (reads != 0 && reads < cfg_limit) begin
            predicted.pulse_valid = 1'b1;
            predicted.pulse_time  = now[NOW_W-1:0];
            captures++;
            if (last_pulse == 0) begin
               // no earlier pulse: predict from the nominal interval
               predicted.next_delay = us_to_delay(interval - poll / 2);
            end else if (now < last_pulse) begin
               predicted.next_delay = '0;
            end else begin
               guard_ns = 64'(cfg_guard);
               guard_ns = guard_ns * NS_PER_US;
               span = now - last_pulse;
               span = (span > guard_ns) ? span - guard_ns : 64'd0;
               predicted.next_delay = (span > DELAY_LIMIT) ? DELAY_LIMIT[DELAY_W-1:0]
                                                            : span[DELAY_W-1:0];
            end
            last_pulse = now;
         end else begin
            predicted.pulse_missed = 1'b1;
            predicted.next_delay   = us_to_delay(poll);
            waiting = 1'b0;
            misses++;
         end
         predicted.waiting_mode = waiting;
         expected_q.push_back(predicted);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic user);
         expiry_result_type want;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: tdata %h tuser %b", data, user);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("next_delay_ns", 64'(want.next_delay), 64'(data[DELAY_W-1:0]));
         compare_field("pulse_valid", 64'(want.pulse_valid), 64'(data[DELAY_W]));
         compare_field("pulse_time_ns", 64'(want.pulse_time),
                       64'(data[DELAY_W+NOW_W:DELAY_W+1]));
         compare_field("pulse_edge", 64'(want.pulse_edge), 64'(user));
         compare_field("pulse_missed", 64'(want.pulse_missed), 64'(data[DELAY_W+NOW_W+1]));
         compare_field("waiting_mode", 64'(want.waiting_mode), 64'(data[DELAY_W+NOW_W+2]));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   pulse_capture_scoreboard_type sb = new();
   logic [NOW_W-1:0]        now_cursor  = '0;
   bit                      steady_flow = 1'b0;
   bit                      stall_rsp   = 1'b0;
   int                      quiet_cycles = 0;

   pps_predictive_edge_capture dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // transaction monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // result sink: random back-pressure plus one long hold-off
   initial begin : rsp_sink
      bit held_off;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_rsp && !held_off) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic send_request(input logic level, input logic [READS_W-1:0] reads,
                               input logic [NOW_W-1:0] now);
      if (!steady_flow) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, reads, level};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering, let every result come back, then let the pipe settle
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, value);
   endtask

   task automatic apply_setting(input logic level, input logic [US_W-1:0] poll,
                                input logic [US_W-1:0] guard, input logic [READS_W-1:0] limit,
                                input logic [US_W-1:0] interval);
      drain_block();
      write_reg(REG_CAPTURE_LEVEL, CSR_DATA_W'(level));
      write_reg(REG_POLL_PERIOD, poll);
      write_reg(REG_GUARD_TIME, guard);
      write_reg(REG_READ_LIMIT, CSR_DATA_W'(limit));
      write_reg(REG_PULSE_INTERVAL, interval);
      // dropped write, nothing may change
      write_reg(REG_UNUSED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      // derived delays are registered from the configuration registers and follow the write
      repeat (2) @(posedge clock);
   endtask

   task automatic send_random_expiry();
      logic                level;
      logic [READS_W-1:0]  reads;
      int                  pick;
      level = 1'($urandom_range(1));
      pick  = $urandom_range(99);
      if (pick < 70 && sb.cfg_limit > 1) reads = READS_W'($urandom_range(sb.cfg_limit - 1, 1));
      else if (pick < 80) reads = '0;
      else if (pick < 92) reads = READS_W'($urandom_range(16'hFFFF, sb.cfg_limit));
      else reads = READS_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 4) now_cursor = NOW_W'({$urandom, $urandom});
      else if (pick < 7) now_cursor = '0;
      else if (pick < 12) now_cursor = now_cursor - NOW_W'($urandom_range(2_000_000_000));
      else now_cursor = now_cursor + NOW_W'(sb.cfg_interval) * NOW_W'(NS_PER_US)
                        + NOW_W'($urandom_range(50000)) - NOW_W'(25000);
      send_request(level, reads, now_cursor);
   endtask

   initial begin : stimulus
      logic [NOW_W-1:0] top_time;
      top_time = '1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: rising capture, poll 100, guard 15, limit 2000
      send_request(1'b0, 16'd0, '0);                        // no change, poll
      send_request(1'b1, 16'd0, NOW_W'(1000));              // rising edge arms
      send_request(1'b0, 16'd1, '0);                        // capture at time zero
      send_request(1'b0, 16'd1999, NOW_W'(64'd1_000_000_000)); // still the first pulse
      send_request(1'b1, 16'd1, NOW_W'(64'd2_000_000_500));
      send_request(1'b0, 16'd5, NOW_W'(64'd1_500_000_000)); // time going backwards
      send_request(1'b0, 16'd100, top_time);                // huge gap saturates
      send_request(1'b1, 16'd2000, top_time);               // count at limit misses
      send_request(1'b1, 16'hFFFF, '0);                     // level unchanged
      send_request(1'b0, 16'hFFFF, '0);                     // falling, wrong edge
      send_request(1'b1, 16'd0, NOW_W'(64'd3_000_000_000));
      send_request(1'b1, 16'd0, NOW_W'(64'd3_000_000_000)); // zero count misses
      send_request(1'b0, 16'd0, '0);
      send_request(1'b1, 16'd0, '0);
      send_request(1'b0, 16'hFFFF, '0);                     // all-ones count misses
      send_request(1'b0, 16'd0, '0);
      send_request(1'b1, 16'h5555, '0);
      send_request(1'b0, 16'd7, NOW_W'(64'd5_000_000_000));
      send_request(1'b1, 16'd9, NOW_W'(64'd5_000_010_000)); // gap below guard
      send_request(1'b0, 16'h0AAA, NOW_W'(64'h2AAA_AAAA_AAAA_AAAA));
      send_request(1'b1, 16'd1, NOW_W'(64'h5555_5555_5555_5555));
      send_request(1'b0, 16'd1, NOW_W'(64'h4000_0000_0000_0000));

      for (int setting_idx = 0; setting_idx < SETTING_COUNT; setting_idx++) begin
         case (setting_idx)
            0: apply_setting(1'b0, 20'd1, 20'd0, 16'd1, 20'd1);
            1: apply_setting(1'b1, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 20'd1);
            2: apply_setting(1'b0, 20'd0, 20'd1_000_000, 16'd0, 20'hFFFFF);
            3: apply_setting(1'b1, 20'd1_000_000, 20'd0, 16'hFFFF, 20'd1_000_000);
            default: apply_setting(1'($urandom_range(1)),
                                   $urandom_range(1) ? US_W'($urandom_range(1000, 1))
                                                     : US_W'($urandom),
                                   $urandom_range(1) ? US_W'($urandom_range(1000))
                                                     : US_W'($urandom),
                                   $urandom_range(1) ? READS_W'($urandom_range(3000, 1))
                                                     : READS_W'($urandom),
                                   $urandom_range(1) ? US_W'($urandom_range(1_000_000, 1))
                                                     : US_W'($urandom));
         endcase
         stall_rsp   = (setting_idx == 3);
         steady_flow = (setting_idx == 5);
         for (int n = 0; n < ITEMS_PER_SETTING; n++) send_random_expiry();
         steady_flow = 1'b0;
      end

      drain_block();
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      $display("ran %0d timer expiries over %0d register writes", sb.expiries, sb.writes);
      $display("captured %0d pulses, missed %0d windows, armed waiting mode %0d times",
               sb.captures, sb.misses, sb.arms);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
